// ===== design/lbc_pkg.sv =====
// Shared constants, types and direction tables for the D2Q9 BGK collision pipeline.
package lbc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned NDIR          = 9;

  // Density and momentum sums of nine 32-bit values.
  localparam int unsigned SUM_W = 36;
  // Quotient bits of a velocity magnitude (saturates at 2^31-1).
  localparam int unsigned QUO_BITS = 31;
  // Partial remainder width: large enough for the divisor shifted by QUO_BITS.
  localparam int unsigned REM_W = SUM_W + QUO_BITS;
  // Width of the equilibrium polynomial.
  localparam int unsigned P_W = 64;
  // Width of the scaled product before the divide by nine.
  localparam int unsigned T_W = 36;

  // Floor division by nine of a T_W-bit value: reciprocal and one correction.
  localparam int unsigned DIV9_SHIFT = 36;
  localparam int unsigned DIV9_MUL_W = 33;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 33'd7635497415;

  // Pipeline depths of the sub-blocks.
  localparam int unsigned SUM_LAT = 3;
  localparam int unsigned DIV_LAT = QUO_BITS + 2;
  localparam int unsigned EQU_LAT = 6;
  localparam int unsigned SCL_LAT = 6;
  localparam int unsigned TOT_LAT = SUM_LAT + DIV_LAT + EQU_LAT + SCL_LAT;

  // Direction order: nw, n, ne, w, c, e, sw, s, se.
  // Projection e.u is taken from one of: ux, uy, ux+uy, ux-uy, or zero.
  localparam int unsigned SRC_UX   = 0;
  localparam int unsigned SRC_UY   = 1;
  localparam int unsigned SRC_SUM  = 2;
  localparam int unsigned SRC_DIFF = 3;
  localparam int unsigned SRC_ZERO = 4;
  localparam int unsigned NSRC     = 4;

  localparam int unsigned EU_SRC [NDIR] = '{SRC_DIFF, SRC_UY, SRC_SUM, SRC_UX, SRC_ZERO,
                                            SRC_UX, SRC_SUM, SRC_UY, SRC_DIFF};
  localparam bit          EU_NEG [NDIR] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                                            1'b0, 1'b1, 1'b1, 1'b0};
  // Weight times 36 is 1, 4 or 16: a left shift.
  localparam int unsigned WT_SHIFT [NDIR] = '{0, 2, 0, 2, 4, 2, 0, 2, 0};

  typedef struct packed {
    logic [SUM_W-1:0] umx;
    logic [SUM_W-1:0] umy;
    logic [SUM_W-1:0] urho;
    logic             negx;
    logic             negy;
    logic             rho_neg;
    logic             rho_zero;
  } lbc_mom_t;

endpackage

// ===== design/lbm_d2q9_bgk_collision_top.sv =====
// Top level of the D2Q9 BGK collision pipeline (tau = 1).
// Usage: one word on the input channel carries the nine Q.FRAC_BITS distribution
// values of a lattice site; one word on the output channel carries the nine
// post-collision values, which with tau fixed at 1 equal the saturated equilibria.
// Both channels use valid/stall: a word moves at a rising edge where valid is
// high and stall is low.
// From input acceptance to the output word, a site passes through the density and
// momentum sums, the bit-per-stage velocity divider, the stages forming the
// equilibrium polynomial and the stages of density scaling, divide by 36R and
// saturation. A new site is accepted every cycle unless the output word is held.
// The whole pipeline advances together. When the output word is held by the
// receiver, every stage freezes and the input channel is stalled in the same
// cycle; while the output register is empty the input is never stalled.
// Reset clears only the per-stage valid bits, so no output word appears until
// a site has travelled the full pipeline. Data registers are not reset.
module lbm_d2q9_bgk_collision_top #(
  parameter int unsigned FRAC_BITS = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lbc_pkg::DATA_W-1:0]   f_nw_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]   f_n_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]   f_ne_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]   f_w_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]   f_c_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]   f_e_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]   f_sw_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]   f_s_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]   f_se_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lbc_pkg::DATA_W-1:0]   out_nw_o,
  output logic signed [lbc_pkg::DATA_W-1:0]   out_n_o,
  output logic signed [lbc_pkg::DATA_W-1:0]   out_ne_o,
  output logic signed [lbc_pkg::DATA_W-1:0]   out_w_o,
  output logic signed [lbc_pkg::DATA_W-1:0]   out_c_o,
  output logic signed [lbc_pkg::DATA_W-1:0]   out_e_o,
  output logic signed [lbc_pkg::DATA_W-1:0]   out_sw_o,
  output logic signed [lbc_pkg::DATA_W-1:0]   out_s_o,
  output logic signed [lbc_pkg::DATA_W-1:0]   out_se_o
);

  localparam int unsigned TOT = lbc_pkg::TOT_LAT;
  localparam int unsigned DLY = lbc_pkg::DIV_LAT + lbc_pkg::EQU_LAT;
  localparam int unsigned ND  = lbc_pkg::NDIR;
  localparam int unsigned DW  = lbc_pkg::DATA_W;

  logic                 en;
  logic [TOT-1:0]       vld_q;
  logic signed [DW-1:0] f_in [ND];
  lbc_pkg::lbc_mom_t    mom;
  logic signed [DW-1:0] ux, uy;
  logic signed [lbc_pkg::P_W-1:0] p [ND];
  logic [lbc_pkg::SUM_W-1:0] urho_dly_q [DLY];
  logic                 rneg_dly_q [DLY];
  logic signed [DW-1:0] res [ND];

  // The pipeline moves unless a finished word is being held at the output.
  assign en          = !(vld_q[TOT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[TOT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT-2:0], in_valid_i};
    end
  end

  assign f_in[0] = f_nw_i;
  assign f_in[1] = f_n_i;
  assign f_in[2] = f_ne_i;
  assign f_in[3] = f_w_i;
  assign f_in[4] = f_c_i;
  assign f_in[5] = f_e_i;
  assign f_in[6] = f_sw_i;
  assign f_in[7] = f_s_i;
  assign f_in[8] = f_se_i;

  lbc_sum u_sum (
    .clk_i (clk_i),
    .en_i  (en),
    .f_i   (f_in),
    .mom_o (mom)
  );

  lbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (mom.umx),
    .den_i  (mom.urho),
    .neg_i  (mom.negx),
    .zero_i (mom.rho_zero),
    .vel_o  (ux)
  );

  lbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (mom.umy),
    .den_i  (mom.urho),
    .neg_i  (mom.negy),
    .zero_i (mom.rho_zero),
    .vel_o  (uy)
  );

  // Density magnitude and sign wait alongside the divider and the polynomial.
  always_ff @(posedge clk_i) begin
    if (en) begin
      urho_dly_q[0] <= mom.urho;
      rneg_dly_q[0] <= mom.rho_neg;
      for (int i = 1; i < DLY; i++) begin
        urho_dly_q[i] <= urho_dly_q[i-1];
        rneg_dly_q[i] <= rneg_dly_q[i-1];
      end
    end
  end

  lbc_equ #(.FRAC_BITS(FRAC_BITS)) u_equ (
    .clk_i (clk_i),
    .en_i  (en),
    .ux_i  (ux),
    .uy_i  (uy),
    .p_o   (p)
  );

  for (genvar d = 0; d < ND; d++) begin : g_scl
    lbc_scl #(
      .FRAC_BITS (FRAC_BITS),
      .WT_SH     (lbc_pkg::WT_SHIFT[d])
    ) u_scl (
      .clk_i     (clk_i),
      .en_i      (en),
      .p_i       (p[d]),
      .urho_i    (urho_dly_q[DLY-1]),
      .rho_neg_i (rneg_dly_q[DLY-1]),
      .out_o     (res[d])
    );
  end

  assign out_nw_o = res[0];
  assign out_n_o  = res[1];
  assign out_ne_o = res[2];
  assign out_w_o  = res[3];
  assign out_c_o  = res[4];
  assign out_e_o  = res[5];
  assign out_sw_o = res[6];
  assign out_s_o  = res[7];
  assign out_se_o = res[8];

  // An accepted word occupies the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted word did not enter the pipeline");

  // A held output word freezes every stage.
  a_hold_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved while the output word was held");

  // Without back-pressure the word in the second-to-last stage arrives at the output.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> (out_valid_o == $past(vld_q[TOT-2])))
    else $error("output valid does not follow the pipeline");

endmodule

// ===== design/lbc_sum.sv =====
// Density and momentum sums with sign/magnitude split, three register stages.
module lbc_sum (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]      f_i [lbc_pkg::NDIR],
  output lbc_pkg::lbc_mom_t                      mom_o
);

  localparam int unsigned PW = lbc_pkg::DATA_W + 2;
  localparam int unsigned SW = lbc_pkg::SUM_W;

  logic signed [PW-1:0] top_q, mid_q, bot_q, lft_q, rgt_q;
  logic signed [SW-1:0] rho_q, mx_q, my_q;
  lbc_pkg::lbc_mom_t    mom_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q <= PW'(f_i[0]) + PW'(f_i[1]) + PW'(f_i[2]);
      mid_q <= PW'(f_i[3]) + PW'(f_i[4]) + PW'(f_i[5]);
      bot_q <= PW'(f_i[6]) + PW'(f_i[7]) + PW'(f_i[8]);
      lft_q <= PW'(f_i[0]) + PW'(f_i[3]) + PW'(f_i[6]);
      rgt_q <= PW'(f_i[2]) + PW'(f_i[5]) + PW'(f_i[8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rho_q <= SW'(top_q) + SW'(mid_q) + SW'(bot_q);
      mx_q  <= SW'(rgt_q) - SW'(lft_q);
      my_q  <= SW'(top_q) - SW'(bot_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mom_q.umx      <= mx_q[SW-1]  ? SW'(-mx_q)  : SW'(mx_q);
      mom_q.umy      <= my_q[SW-1]  ? SW'(-my_q)  : SW'(my_q);
      mom_q.urho     <= rho_q[SW-1] ? SW'(-rho_q) : SW'(rho_q);
      mom_q.negx     <= mx_q[SW-1] ^ rho_q[SW-1];
      mom_q.negy     <= my_q[SW-1] ^ rho_q[SW-1];
      mom_q.rho_neg  <= rho_q[SW-1];
      mom_q.rho_zero <= (rho_q == '0);
    end
  end

  assign mom_o = mom_q;

endmodule

// ===== design/lbc_div.sv =====
// Pipelined restoring divider giving one saturated signed velocity component.
module lbc_div #(
  parameter int unsigned FRAC_BITS = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [lbc_pkg::SUM_W-1:0]           num_i,
  input  logic [lbc_pkg::SUM_W-1:0]           den_i,
  input  logic                                neg_i,
  input  logic                                zero_i,
  output logic signed [lbc_pkg::DATA_W-1:0]   vel_o
);

  localparam int unsigned QB = lbc_pkg::QUO_BITS;
  localparam int unsigned RW = lbc_pkg::REM_W;
  localparam int unsigned SW = lbc_pkg::SUM_W;
  localparam int unsigned DW = lbc_pkg::DATA_W;

  logic [RW-1:0] num_ext, den_top;
  logic [RW-1:0] rem_q [QB];
  logic [SW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB+1];
  logic          ovf_q [QB+1];
  logic          neg_q [QB+1];
  logic          zero_q [QB+1];
  logic [RW-1:0] trial [QB];
  logic          ge [QB];
  logic [DW-1:0] mag;
  logic signed [DW-1:0] vel_q;

  assign num_ext = RW'(num_i) << FRAC_BITS;
  assign den_top = RW'(den_i) << QB;

  // Setup stage: the quotient reaches 2^31 exactly when N >= D * 2^31.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_ext;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      ovf_q[0]  <= (num_ext >= den_top);
      neg_q[0]  <= neg_i;
      zero_q[0] <= zero_i;
    end
  end

  always_comb begin
    for (int s = 0; s < QB; s++) begin
      trial[s] = RW'(den_q[s]) << (QB - 1 - s);
      ge[s]    = (rem_q[s] >= trial[s]);
    end
  end

  // One quotient bit per stage, most significant first.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QB; s++) begin
        if (s < QB - 1) begin
          rem_q[s+1] <= ge[s] ? rem_q[s] - trial[s] : rem_q[s];
          den_q[s+1] <= den_q[s];
        end
        quo_q[s+1]  <= quo_q[s] | (QB'(ge[s]) << (QB - 1 - s));
        ovf_q[s+1]  <= ovf_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  always_comb begin
    if (zero_q[QB]) begin
      mag = '0;
    end else if (ovf_q[QB]) begin
      mag = {1'b0, {QB{1'b1}}};
    end else begin
      mag = DW'(quo_q[QB]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vel_q <= neg_q[QB] ? -$signed(mag) : $signed(mag);
    end
  end

  assign vel_o = vel_q;

endmodule

// ===== design/lbc_equ.sv =====
// Equilibrium polynomial P = R + 3eu + 4.5eu^2 - 1.5u^2 for all nine directions.
module lbc_equ #(
  parameter int unsigned FRAC_BITS = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]   ux_i,
  input  logic signed [lbc_pkg::DATA_W-1:0]   uy_i,
  output logic signed [lbc_pkg::P_W-1:0]      p_o [lbc_pkg::NDIR]
);

  localparam int unsigned DW = lbc_pkg::DATA_W;
  localparam int unsigned EW = DW + 1;
  localparam int unsigned TW = DW + 3;
  localparam int unsigned PW = lbc_pkg::P_W;
  localparam int unsigned NS = lbc_pkg::NSRC;
  localparam int unsigned ND = lbc_pkg::NDIR;
  localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

  logic signed [EW-1:0] src1_q [NS];
  logic signed [EW-1:0] src2_q [NS];
  logic signed [EW-1:0] src3_q [NS];
  logic signed [EW-1:0] src4_q [NS];
  logic [DW-1:0]        mag2_q [NS];
  logic [PW-1:0]        sq3_q  [NS];
  logic [PW-1:0]        h94_q  [NS];
  logic [PW-1:0]        usq4_q;
  logic [PW-1:0]        u35_q;
  logic [PW-1:0]        c5_q   [NS+1];
  logic signed [TW-1:0] eu35_q [ND];
  logic signed [TW-1:0] eu3_d  [ND];
  logic signed [PW-1:0] p6_q   [ND];
  logic [PW-1:0]        eu2    [NS];

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      eu2[i] = sq3_q[i] >> FRAC_BITS;
    end
  end

  // Three times the signed projection for each direction.
  always_comb begin
    for (int d = 0; d < ND; d++) begin
      if (lbc_pkg::EU_SRC[d] == lbc_pkg::SRC_ZERO) begin
        eu3_d[d] = '0;
      end else if (lbc_pkg::EU_NEG[d]) begin
        eu3_d[d] = -(TW'(src4_q[lbc_pkg::EU_SRC[d]]) + (TW'(src4_q[lbc_pkg::EU_SRC[d]]) <<< 1));
      end else begin
        eu3_d[d] = TW'(src4_q[lbc_pkg::EU_SRC[d]]) + (TW'(src4_q[lbc_pkg::EU_SRC[d]]) <<< 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Projections ux, uy, ux+uy, ux-uy.
      src1_q[lbc_pkg::SRC_UX]   <= EW'(ux_i);
      src1_q[lbc_pkg::SRC_UY]   <= EW'(uy_i);
      src1_q[lbc_pkg::SRC_SUM]  <= EW'(ux_i) + EW'(uy_i);
      src1_q[lbc_pkg::SRC_DIFF] <= EW'(ux_i) - EW'(uy_i);
      for (int i = 0; i < NS; i++) begin
        mag2_q[i] <= src1_q[i][EW-1] ? DW'(-src1_q[i]) : DW'(src1_q[i]);
        src2_q[i] <= src1_q[i];
        sq3_q[i]  <= PW'(mag2_q[i]) * PW'(mag2_q[i]);
        src3_q[i] <= src2_q[i];
        h94_q[i]  <= ((eu2[i] << 3) + eu2[i]) >> 1;
        src4_q[i] <= src3_q[i];
        c5_q[i]   <= ONE + h94_q[i];
      end
      usq4_q <= (sq3_q[lbc_pkg::SRC_UX] + sq3_q[lbc_pkg::SRC_UY]) >> FRAC_BITS;
      u35_q  <= ((usq4_q << 1) + usq4_q) >> 1;
      c5_q[lbc_pkg::SRC_ZERO] <= ONE;
      for (int d = 0; d < ND; d++) begin
        eu35_q[d] <= eu3_d[d];
        p6_q[d]   <= $signed(c5_q[lbc_pkg::EU_SRC[d]]) + PW'(eu35_q[d]) - $signed(u35_q);
      end
    end
  end

  assign p_o = p6_q;

endmodule

// ===== design/lbc_scl.sv =====
// Weighted scaling by density, divide by 36R and 32-bit saturation for one direction.
module lbc_scl #(
  parameter int unsigned FRAC_BITS = lbc_pkg::FRAC_BITS_DEF,
  parameter int unsigned WT_SH     = 0
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [lbc_pkg::P_W-1:0]      p_i,
  input  logic [lbc_pkg::SUM_W-1:0]           urho_i,
  input  logic                                rho_neg_i,
  output logic signed [lbc_pkg::DATA_W-1:0]   out_o
);

  localparam int unsigned SW  = lbc_pkg::SUM_W;
  localparam int unsigned AW  = lbc_pkg::P_W - 1;
  localparam int unsigned LW  = 32 + SW;
  localparam int unsigned HW  = AW - 32 + SW;
  localparam int unsigned ABW = AW + SW;
  localparam int unsigned XW  = ABW + 4;
  localparam int unsigned TW  = lbc_pkg::T_W;
  localparam int unsigned MW  = TW + lbc_pkg::DIV9_MUL_W;
  localparam int unsigned QW  = MW - lbc_pkg::DIV9_SHIFT;
  localparam int unsigned DW  = lbc_pkg::DATA_W;

  logic [AW-1:0]  a1_q;
  logic [SW-1:0]  urho1_q;
  logic           neg1_q, neg2_q, neg3_q, neg4_q, neg5_q;
  logic [LW-1:0]  lo2_q;
  logic [HW-1:0]  hi2_q;
  logic [ABW-1:0] ab;
  logic [XW-1:0]  t_all;
  logic [TW-1:0]  t3_q, t4_q;
  logic           big3_q, big4_q, big5_q;
  logic [MW-1:0]  pr4_q;
  logic [QW-1:0]  q0;
  logic [QW+3:0]  n9, rr;
  logic [QW-1:0]  q05_q;
  logic           inc5_q;
  logic [QW:0]    q;
  logic signed [DW-1:0] res_d, res_q;

  assign ab    = (ABW'(hi2_q) << 32) + ABW'(lo2_q);
  assign t_all = (XW'(ab) << WT_SH) >> (FRAC_BITS + 2);
  assign q0    = pr4_q[MW-1:lbc_pkg::DIV9_SHIFT];
  assign n9    = ((QW+4)'(q0) << 3) + (QW+4)'(q0);
  assign rr    = (QW+4)'(t4_q) - n9;
  assign q     = (QW+1)'(q05_q) + (QW+1)'(inc5_q);

  // Result magnitude saturates at 2^31-1, or 2^31 when negative.
  always_comb begin
    if (!neg5_q) begin
      if (big5_q || q > (QW+1)'(32'h7FFF_FFFF)) begin
        res_d = 32'sh7FFF_FFFF;
      end else begin
        res_d = $signed(q[DW-1:0]);
      end
    end else begin
      if (big5_q || q > (QW+1)'(33'h1_0000_0000 >> 1)) begin
        res_d = $signed(32'h8000_0000);
      end else begin
        res_d = -$signed(q[DW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= p_i[lbc_pkg::P_W-1] ? AW'(-p_i) : AW'(p_i);
      urho1_q <= urho_i;
      neg1_q  <= p_i[lbc_pkg::P_W-1] ^ rho_neg_i;
      lo2_q   <= LW'(a1_q[31:0]) * LW'(urho1_q);
      hi2_q   <= HW'(a1_q[AW-1:32]) * HW'(urho1_q);
      neg2_q  <= neg1_q;
      t3_q    <= t_all[TW-1:0];
      big3_q  <= |t_all[XW-1:TW];
      neg3_q  <= neg2_q;
      pr4_q   <= MW'(t3_q) * MW'(lbc_pkg::DIV9_MUL);
      t4_q    <= t3_q;
      big4_q  <= big3_q;
      neg4_q  <= neg3_q;
      q05_q   <= q0;
      inc5_q  <= (rr >= (QW+4)'(9));
      big5_q  <= big4_q;
      neg5_q  <= neg4_q;
      res_q   <= res_d;
    end
  end

  assign out_o = res_q;

endmodule
